[rtl/core/apm1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PM1 register block package
// Shared types and constants for the PM1 event/control registers and the
// power-management timer.
// ----------------------------------------------------------------------------
package apm1_pkg;

   // Operation carried by each request word
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Access sizes in bytes
   localparam logic [2:0] SZ_BYTE  = 3'd1;
   localparam logic [2:0] SZ_WORD  = 3'd2;
   localparam logic [2:0] SZ_DWORD = 3'd4;

   // Byte offsets within the register block
   localparam logic [3:0] OFS_STATUS     = 4'd0;
   localparam logic [3:0] OFS_STATUS_HI  = 4'd1;
   localparam logic [3:0] OFS_ENABLE     = 4'd2;
   localparam logic [3:0] OFS_ENABLE_HI  = 4'd3;
   localparam logic [3:0] OFS_CONTROL    = 4'd4;
   localparam logic [3:0] OFS_CONTROL_HI = 4'd5;
   localparam logic [3:0] OFS_TIMER      = 4'd8;

   // Register bits
   localparam logic [15:0] OVF_BIT    = 16'h0001;
   localparam logic [15:0] GBL_BIT    = 16'h0020;
   localparam logic [15:0] SCI_ENABLE = 16'h0001;

   // Default timer width before it wraps
   localparam int TIMER_BITS_DEFAULT = 24;

endpackage

[rtl/core/apm1_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PM1 request channel
// Valid/ready channel carrying one tick, read or write word.
// ----------------------------------------------------------------------------
interface apm1_req_if
   import apm1_pkg::*;
   ;
   logic        valid;
   logic        ready;
   op_type      op;
   logic [3:0]  offset;
   logic [2:0]  access_bytes;
   logic [31:0] write_data;

   modport source (output valid, output op, output offset, output access_bytes,
                   output write_data, input ready);
   modport sink   (input valid, input op, input offset, input access_bytes,
                   input write_data, output ready);
endinterface

[rtl/core/apm1_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PM1 response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface apm1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        sci_event;
   logic        access_ok;

   modport source (output valid, output read_data, output sci_event,
                   output access_ok, input ready);
   modport sink   (input valid, input read_data, input sci_event,
                   input access_ok, output ready);
endinterface

[rtl/core/acpi_pm1_register_block.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PM1 register block with power-management timer
// Status, enable and control registers plus a wrapping PM timer, driven by
// tick, read and write words on one request channel.
// ----------------------------------------------------------------------------
// Each request word is captured in an input register and executed when the
// output register is free or being taken; the register update and the timer
// increment are done in one pass and the result lands in an output register.
// A result is presented once its word has passed the input register, the
// execute stage and the output register, and one request is accepted in every
// cycle as long as the response side keeps taking words; the register file is
// updated once per word, so back-to-back words always see the effect of the
// word before them. Unmapped accesses read 0, change nothing and return
// access_ok low.
module acpi_pm1_register_block
   import apm1_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   apm1_req_if.sink     req_chan,
   apm1_rsp_if.source   rsp_chan
);

   // Input register
   logic        in_valid_ff;
   op_type      in_op_ff;
   logic [3:0]  in_offset_ff;
   logic [2:0]  in_size_ff;
   logic [31:0] in_data_ff;

   // Architectural state
   logic [15:0] status_ff, status_in;
   logic [15:0] enable_ff, enable_in;
   logic [15:0] control_ff, control_in;
   logic [31:0] timer_ff, timer_in;

   // Output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_sci_ff, rsp_sci_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic        advance;
   logic        execute;
   logic [32:0] timer_sum;
   logic        timer_ovf;
   logic        byte_hit;
   logic        word_hit;
   logic        dword_hit;
   logic        is_write;
   logic [15:0] byte_reg;

   // Replace one byte of a 16-bit register
   function automatic logic [15:0] set_byte(input logic [15:0] value,
                                            input logic high,
                                            input logic [7:0] data);
      logic [15:0] result;
      result = high ? {data, value[7:0]} : {value[15:8], data};
      return result;
   endfunction

   // Write-one-to-clear of the overflow and global status bits
   function automatic logic [15:0] status_w1c(input logic [15:0] value,
                                              input logic [15:0] data);
      logic [15:0] clear;
      clear = data & (OVF_BIT | GBL_BIT);
      return value & ~clear;
   endfunction

   // Handshake: the execute stage moves when the output register is free
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign execute        = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   // Capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff     <= req_chan.op;
         in_offset_ff <= req_chan.offset;
         in_size_ff   <= req_chan.access_bytes;
         in_data_ff   <= req_chan.write_data;
      end
   end

   // Address decode
   assign byte_hit  = (in_size_ff == SZ_BYTE) && (in_offset_ff <= OFS_CONTROL_HI);
   assign word_hit  = (in_size_ff == SZ_WORD) &&
                      (in_offset_ff inside {OFS_STATUS, OFS_ENABLE, OFS_CONTROL});
   assign dword_hit = (in_size_ff == SZ_DWORD) &&
                      (in_offset_ff inside {OFS_STATUS, OFS_TIMER});
   assign is_write  = (in_op_ff == OP_WRITE);

   // Timer increment; overflow once the count reaches the wrap point
   assign timer_sum = {1'b0, timer_ff} + 33'd1;
   assign timer_ovf = |timer_sum[32:TIMER_BITS];

   // Register selected for a byte access
   always_comb begin
      case (in_offset_ff[2:1])
         2'd0:    byte_reg = status_ff;
         2'd1:    byte_reg = enable_ff;
         default: byte_reg = control_ff;
      endcase
   end

   // Execute one word: next register state and result
   always_comb begin
      status_in   = status_ff;
      enable_in   = enable_ff;
      control_in  = control_ff;
      timer_in    = timer_ff;
      rsp_data_in = '0;
      rsp_sci_in  = 1'b0;
      rsp_ok_in   = 1'b0;
      case (in_op_ff)
         OP_TICK: begin
            rsp_ok_in = 1'b1;
            if (timer_ovf) begin
               timer_in  = '0;
               status_in = status_ff | OVF_BIT;
               if ((enable_ff & OVF_BIT) != '0) begin
                  rsp_sci_in = 1'b1;
                  enable_in  = '0;
               end
            end else begin
               timer_in = timer_sum[31:0];
            end
         end
         OP_READ, OP_WRITE: begin
            if (byte_hit) begin
               rsp_ok_in = 1'b1;
               if (!is_write) begin
                  rsp_data_in = {24'd0, in_offset_ff[0] ? byte_reg[15:8] : byte_reg[7:0]};
               end else begin
                  case (in_offset_ff)
                     OFS_STATUS: begin
                        status_in = status_w1c(status_ff, {8'd0, in_data_ff[7:0]});
                     end
                     OFS_STATUS_HI: begin
                        status_in = set_byte(status_ff, 1'b1, in_data_ff[7:0]);
                     end
                     OFS_ENABLE, OFS_ENABLE_HI: begin
                        enable_in = set_byte(enable_ff, in_offset_ff[0], in_data_ff[7:0]);
                     end
                     default: begin
                        control_in = set_byte(control_ff, in_offset_ff[0], in_data_ff[7:0]);
                     end
                  endcase
               end
            end else if (word_hit) begin
               rsp_ok_in = 1'b1;
               case (in_offset_ff)
                  OFS_STATUS: begin
                     if (is_write) status_in = status_w1c(status_ff, in_data_ff[15:0]);
                     else rsp_data_in = {16'd0, status_ff};
                  end
                  OFS_ENABLE: begin
                     if (is_write) enable_in = in_data_ff[15:0];
                     else rsp_data_in = {16'd0, enable_ff};
                  end
                  default: begin
                     if (is_write) control_in = in_data_ff[15:0];
                     else rsp_data_in = {16'd0, control_ff};
                  end
               endcase
            end else if (dword_hit) begin
               rsp_ok_in = 1'b1;
               if (in_offset_ff == OFS_STATUS) begin
                  if (is_write) begin
                     status_in = in_data_ff[15:0];
                     enable_in = in_data_ff[31:16];
                  end else begin
                     rsp_data_in = {enable_ff, status_ff};
                  end
               end else begin
                  if (is_write) timer_in = in_data_ff;
                  else rsp_data_in = timer_ff;
               end
            end
         end
         default: begin
            rsp_ok_in = 1'b0;
         end
      endcase
   end

   // Register state, updated once per executed word
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= '0;
         enable_ff  <= '0;
         control_ff <= SCI_ENABLE;
         timer_ff   <= '0;
      end else if (execute) begin
         status_ff  <= status_in;
         enable_ff  <= enable_in;
         control_ff <= control_in;
         timer_ff   <= timer_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (execute) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sci_ff  <= rsp_sci_in;
         rsp_ok_ff   <= rsp_ok_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.sci_event = rsp_sci_ff;
   assign rsp_chan.access_ok = rsp_ok_ff;

   // An SCI is only ever reported on a successful tick
   a_sci_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sci_ff |-> rsp_ok_ff)
      else $error("SCI reported without access_ok");

   // A firing overflow leaves the enable register cleared
   a_sci_clears_enable: assert property (@(posedge clock) disable iff (reset)
      execute && rsp_sci_in |=> enable_ff == '0)
      else $error("enable register not cleared after SCI");

   // A timer overflow on a tick sets the overflow status bit
   a_ovf_status: assert property (@(posedge clock) disable iff (reset)
      execute && (in_op_ff == OP_TICK) && timer_ovf |=> status_ff[0])
      else $error("overflow status bit not set");

   // A new result only follows an executed word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a word in execution");

endmodule
